FILE: sv/rrtp_pkg.sv
package rrtp_pkg;

  localparam int SLOTS_DEF = 1024;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 10;
  localparam int DEC_W     = 3;

  // slot status codes
  localparam logic [STATUS_W-1:0] STAT_FREE     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_DYING    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RUNNABLE = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RUNNING  = 3'd3;

  // commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_YIELD = 1'b1;

  // decisions
  localparam logic [DEC_W-1:0] DEC_RUN    = 3'd0;
  localparam logic [DEC_W-1:0] DEC_RERUN  = 3'd1;
  localparam logic [DEC_W-1:0] DEC_HALT   = 3'd2;
  localparam logic [DEC_W-1:0] DEC_NOLIVE = 3'd3;
  localparam logic [DEC_W-1:0] DEC_WRITE  = 3'd4;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [DEC_W-1:0]  decision;
    logic [SLOT_W-1:0] chosen_slot;
  } res_t;

endpackage

FILE: sv/rrtp_ram.sv
module rrtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/rrtp_ctrl.sv
module rrtp_ctrl #(
  parameter int SLOTS = rrtp_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [rrtp_pkg::SLOT_W-1:0]         slot_index,
  input  logic [rrtp_pkg::STATUS_W-1:0]       new_status,
  output logic                                ram_we,
  output logic [$clog2(SLOTS)-1:0]            ram_addr,
  output logic [rrtp_pkg::STATUS_W-1:0]       ram_wdata,
  input  logic [rrtp_pkg::STATUS_W-1:0]       ram_rdata,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rrtp_pkg::res_t                      res
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int IW = (AW > rrtp_pkg::SLOT_W) ? AW : rrtp_pkg::SLOT_W;

  rrtp_pkg::state_t state, state_next;
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          rd_vld, rd_vld_next;
  logic [AW-1:0] rd_pos, rd_pos_next;
  logic [AW-1:0] cur_slot, cur_slot_next;
  logic          cur_valid, cur_valid_next;
  logic          cur_run, cur_run_next;
  logic          any_alive, any_alive_next;
  rrtp_pkg::res_t res_next;

  logic          issue;
  logic          hit_cur;
  logic          alive;
  logic          in_range;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    next_pos = (p == AW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  // low bits of a slot number as reported on the output
  function automatic logic [rrtp_pkg::SLOT_W-1:0] to_slot(input logic [AW-1:0] s);
    logic [IW-1:0] ext;
    ext = IW'(s);
    to_slot = ext[rrtp_pkg::SLOT_W-1:0];
  endfunction

  assign in_range = 32'(slot_index) < 32'(SLOTS);
  assign issue    = cnt != CW'(SLOTS);
  assign hit_cur  = cur_valid && (rd_pos == cur_slot) && (ram_rdata == rrtp_pkg::STAT_RUNNING);
  assign alive    = (ram_rdata == rrtp_pkg::STAT_DYING) ||
                    (ram_rdata == rrtp_pkg::STAT_RUNNABLE) ||
                    (ram_rdata == rrtp_pkg::STAT_RUNNING);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrtp_pkg::ST_CLEAR;
      pos       <= '0;
      cnt       <= '0;
      rd_vld    <= 1'b0;
      cur_slot  <= '0;
      cur_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      cnt       <= cnt_next;
      rd_vld    <= rd_vld_next;
      cur_slot  <= cur_slot_next;
      cur_valid <= cur_valid_next;
    end
    rd_pos    <= rd_pos_next;
    cur_run   <= cur_run_next;
    any_alive <= any_alive_next;
    res       <= res_next;
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    cnt_next       = cnt;
    rd_vld_next    = rd_vld;
    rd_pos_next    = rd_pos;
    cur_slot_next  = cur_slot;
    cur_valid_next = cur_valid;
    cur_run_next   = cur_run;
    any_alive_next = any_alive;
    res_next       = res;
    ram_we         = 1'b0;
    ram_addr       = pos;
    ram_wdata      = new_status;
    in_ready       = 1'b0;
    res_valid      = 1'b0;

    case (state)
      rrtp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = rrtp_pkg::STAT_FREE;
        pos_next  = next_pos(pos);
        if (pos == AW'(SLOTS - 1)) begin
          state_next = rrtp_pkg::ST_IDLE;
        end
      end

      rrtp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cmd == rrtp_pkg::CMD_WRITE) begin
            ram_we               = in_range;
            ram_addr             = AW'(slot_index);
            res_next.decision    = rrtp_pkg::DEC_WRITE;
            res_next.chosen_slot = '0;
            state_next           = rrtp_pkg::ST_RESP;
          end else begin
            pos_next       = cur_valid ? next_pos(cur_slot) : AW'(1);
            cnt_next       = '0;
            rd_vld_next    = 1'b0;
            cur_run_next   = 1'b0;
            any_alive_next = 1'b0;
            state_next     = rrtp_pkg::ST_SCAN;
          end
        end
      end

      rrtp_pkg::ST_SCAN: begin
        // one read issued per cycle, data checked in the following cycle
        rd_vld_next = issue;
        rd_pos_next = pos;
        if (issue) begin
          pos_next = next_pos(pos);
          cnt_next = cnt + 1'b1;
        end
        if (rd_vld) begin
          cur_run_next   = cur_run | hit_cur;
          any_alive_next = any_alive | alive;
          if (ram_rdata == rrtp_pkg::STAT_RUNNABLE) begin
            cur_slot_next        = rd_pos;
            cur_valid_next       = 1'b1;
            res_next.decision    = rrtp_pkg::DEC_RUN;
            res_next.chosen_slot = to_slot(rd_pos);
            state_next           = rrtp_pkg::ST_RESP;
          end else if (!issue) begin
            // last entry seen, nothing runnable
            state_next = rrtp_pkg::ST_RESP;
            if (cur_run || hit_cur) begin
              res_next.decision    = rrtp_pkg::DEC_RERUN;
              res_next.chosen_slot = to_slot(cur_slot);
            end else if (any_alive || alive) begin
              res_next.decision    = rrtp_pkg::DEC_HALT;
              res_next.chosen_slot = '0;
              cur_valid_next       = 1'b0;
              cur_slot_next        = '0;
            end else begin
              res_next.decision    = rrtp_pkg::DEC_NOLIVE;
              res_next.chosen_slot = '0;
            end
          end
        end
      end

      rrtp_pkg::ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = rrtp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rrtp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/round_robin_task_picker.sv
// Round-robin task picker over a table of SLOTS task slot status codes.
// Input channel (in_valid/in_ready): one word per command. cmd = write stores
// new_status at slot_index (indices >= SLOTS store nothing) and answers
// "write done". cmd = yield scans the table circularly from just after the
// current slot (slot 1 if none) for a runnable slot; failing that it reruns
// a still-running current slot, halts, or reports no live slot.
// Output channel (out_valid/out_ready): exactly one word per input word,
// decision and chosen_slot, held in an output register.
// Throughput: one command at a time. A write moves from accept straight to the
// response state. A yield reads the status RAM one entry per cycle, stopping
// at the first runnable slot or once the whole table has been scanned.
// Reset: rst (synchronous) clears the current slot, then a clearing pass
// writes every RAM entry to free, during which in_ready is low.
// Stall: while the output word waits, the next command can be accepted and
// processed; its result waits inside until the output register frees up.
module round_robin_task_picker #(
  parameter int SLOTS = rrtp_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [rrtp_pkg::SLOT_W-1:0]         slot_index,
  input  logic [rrtp_pkg::STATUS_W-1:0]       new_status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rrtp_pkg::DEC_W-1:0]          decision,
  output logic [rrtp_pkg::SLOT_W-1:0]         chosen_slot
);

  localparam int AW = $clog2(SLOTS);

  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [rrtp_pkg::STATUS_W-1:0] ram_wdata;
  logic [rrtp_pkg::STATUS_W-1:0] ram_rdata;
  logic                          res_valid;
  logic                          res_ready;
  rrtp_pkg::res_t                res;

  rrtp_ram #(
    .WIDTH (rrtp_pkg::STATUS_W),
    .DEPTH (SLOTS)
  ) u_status_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  rrtp_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .slot_index (slot_index),
    .new_status (new_status),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      decision    <= res.decision;
      chosen_slot <= res.chosen_slot;
    end
  end

endmodule
